// ----- hdl/rect_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RECTANGLE encryption core.
// Used by rect_cell, rect_chain and rectangle_block_encrypt; depends on nothing.
package rect_pkg;

   localparam int ROW_W     = 16;
   localparam int NUM_ROWS  = 4;
   localparam int BLOCK_W   = ROW_W * NUM_ROWS;
   localparam int KEY_IDX_W = 5;

   // Left rotations applied to rows 1, 2 and 3 after the S-box layer.
   localparam int ROT_ROW1 = 1;
   localparam int ROT_ROW2 = 12;
   localparam int ROT_ROW3 = 13;

   localparam logic OP_LOAD_KEY = 1'b0;
   localparam logic OP_ENCRYPT  = 1'b1;

   typedef logic [NUM_ROWS-1:0] rect_col_type;

   typedef struct packed {
      logic load;
      logic step;
   } rect_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_WHITEN
   } rect_state_type;

endpackage

// ----- hdl/rect_cell.sv -----
`timescale 1ns / 1ps
// One column cell: holds one 4-bit column of the state and applies the S-box to it.
// Depends on rect_pkg.
module rect_cell (
   input  logic                   clock,
   input  rect_pkg::rect_ctl_type ctl,
   input  rect_pkg::rect_col_type load_col,
   input  rect_pkg::rect_col_type key_col,
   input  logic                   row1_in,
   input  logic                   row2_in,
   input  logic                   row3_in,
   output rect_pkg::rect_col_type col,
   output rect_pkg::rect_col_type sbox_out
);
   import rect_pkg::*;

   rect_col_type col_ff;
   rect_col_type col_in;
   rect_col_type a;
   logic         n1, x23, x12, v, b0;

   // The column is keyed first, then substituted in plain gates.
   always_comb begin
      a        = col_ff ^ key_col;
      n1       = ~a[1];
      x23      = a[2] ^ a[3];
      x12      = a[1] ^ a[2];
      b0       = (a[0] & n1) ^ x23;
      v        = a[0] ^ (a[3] | n1);
      sbox_out = {x12 ^ (x23 & v), v ^ (b0 | x12), a[2] ^ v, b0};
   end

   // Row 0 stays in place; the other rows arrive from the cells that the rotation names.
   always_comb begin
      priority if (ctl.load) begin
         col_in = load_col;
      end else if (ctl.step) begin
         col_in = {row3_in, row2_in, row1_in, sbox_out[0]};
      end else begin
         col_in = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col = col_ff;

endmodule

// ----- hdl/rect_chain.sv -----
`timescale 1ns / 1ps
// Row of sixteen column cells wired for the RECTANGLE row rotations.
// Depends on rect_pkg and rect_cell.
module rect_chain (
   input  logic                              clock,
   input  rect_pkg::rect_ctl_type            ctl,
   input  logic [rect_pkg::BLOCK_W-1:0]      load_block,
   input  logic [rect_pkg::BLOCK_W-1:0]      round_key,
   output logic [rect_pkg::BLOCK_W-1:0]      block
);
   import rect_pkg::*;

   rect_col_type sbox_col [ROW_W];
   rect_col_type cur_col  [ROW_W];

   for (genvar c = 0; c < ROW_W; c++) begin : g_col
      // A left rotation by r takes the new bit c from the old bit c - r.
      localparam int SRC1 = (c + ROW_W - ROT_ROW1) % ROW_W;
      localparam int SRC2 = (c + ROW_W - ROT_ROW2) % ROW_W;
      localparam int SRC3 = (c + ROW_W - ROT_ROW3) % ROW_W;

      rect_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_col ({load_block[3*ROW_W+c], load_block[2*ROW_W+c],
                     load_block[ROW_W+c], load_block[c]}),
         .key_col  ({round_key[3*ROW_W+c], round_key[2*ROW_W+c],
                     round_key[ROW_W+c], round_key[c]}),
         .row1_in  (sbox_col[SRC1][1]),
         .row2_in  (sbox_col[SRC2][2]),
         .row3_in  (sbox_col[SRC3][3]),
         .col      (cur_col[c]),
         .sbox_out (sbox_col[c])
      );

      assign block[c]         = cur_col[c][0];
      assign block[ROW_W+c]   = cur_col[c][1];
      assign block[2*ROW_W+c] = cur_col[c][2];
      assign block[3*ROW_W+c] = cur_col[c][3];
   end

endmodule

// ----- hdl/rectangle_block_encrypt.sv -----
`timescale 1ns / 1ps
// RECTANGLE 64-bit block encryption with a store of precomputed round keys.
// Depends on rect_pkg and rect_chain.
//
// Request words carry an op code. A load (op 0) writes round_key into slot
// key_index of the key store in the cycle it is accepted and gives no response;
// a slot above ROUNDS is ignored. An encrypt (op 1) gives one response word
// holding the ciphertext. All ROUNDS+1 keys must be loaded before encrypting.
// The state sits in a row of sixteen column cells; each cycle one round runs
// through all of them, fed by one key read from the store; an encryption
// runs ROUNDS rounds (25 by default) and then the final key addition. The
// response register is loaded in the whitening state once the output is free.
// req_stall is high while an encryption is in the core, so a new block is
// accepted only after the previous one has left the core; loads are taken
// one per cycle when the core is free. A waiting response does not block the
// next request; the core only holds its finished block while rsp_stall keeps
// the previous response in place. Reset empties the core and the response
// register; the key store is not cleared.
module rectangle_block_encrypt #(
   parameter int ROUNDS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [rect_pkg::KEY_IDX_W-1:0]      req_key_index,
   input  logic [rect_pkg::BLOCK_W-1:0]        req_round_key,
   input  logic [rect_pkg::BLOCK_W-1:0]        req_plaintext,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rect_pkg::BLOCK_W-1:0]        rsp_ciphertext
);
   import rect_pkg::*;

   localparam int SLOTS = ROUNDS + 1;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [BLOCK_W-1:0] key_mem [SLOTS];
   logic [BLOCK_W-1:0] key_ff;

   rect_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   rnd_ff, rnd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_data_ff;
   logic [BLOCK_W-1:0] block;
   rect_ctl_type       ctl;
   logic               req_take, start, key_wr, key_rd, rsp_load, out_free;
   logic [IDX_W-1:0]   rd_addr;

   assign req_take = req_valid && !req_stall;
   assign start    = req_take && (req_op == OP_ENCRYPT);
   assign key_wr   = req_take && (req_op == OP_LOAD_KEY) &&
                     (req_key_index <= KEY_IDX_W'(ROUNDS));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      ctl          = '0;
      key_rd       = 1'b0;
      rd_addr      = rnd_ff + IDX_W'(1);
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               key_rd   = 1'b1;
               rd_addr  = '0;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            ctl.step = 1'b1;
            key_rd   = 1'b1;
            rnd_in   = rnd_ff + IDX_W'(1);
            if (rnd_ff == IDX_W'(ROUNDS - 1)) begin
               state_in = ST_WHITEN;
            end
         end
         ST_WHITEN: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Key store: one write port for loads, one registered read port for the rounds.
   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[req_key_index[IDX_W-1:0]] <= req_round_key;
      end
      if (key_rd) begin
         key_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= block ^ key_ff;
      end
   end

   rect_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .load_block (req_plaintext),
      .round_key  (key_ff),
      .block      (block)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_data_ff;

   a_round_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff < IDX_W'(ROUNDS)))
      else $error("round counter ran past the last round");

   a_start_enters_rounds: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_ROUND) && (rnd_ff == '0))
      else $error("accepted encryption did not start at round zero");

   a_response_from_whiten: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WHITEN))
      else $error("response appeared without a finished block");

   a_whiten_completes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WHITEN) && out_free) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("finished block was not handed to the response register");

endmodule
